@@ design/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCCA_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MCCA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/mcca_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mcca_pkg;

    localparam int NUM_CH   = 64;
    localparam int CH_W     = $clog2(NUM_CH);
    localparam int CHX_W    = CH_W + 1;
    localparam int CDEPTH   = 2 * NUM_CH;
    localparam int CADDR_W  = $clog2(CDEPTH);
    localparam int NPAIRS   = NUM_CH * (NUM_CH - 1) / 2;
    localparam int SLOT_W   = $clog2(NPAIRS);
    localparam int PDEPTH   = 2 * NPAIRS;
    localparam int PADDR_W  = $clog2(PDEPTH);
    localparam int VAL_W    = 21;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 64;
    localparam int CFG_W    = 7;
    localparam int PROD_W   = CH_W + CHX_W;

    localparam logic REG_COV_EN    = 1'b0;
    localparam logic REG_CH_IN_USE = 1'b1;

    localparam logic [2:0] KIND_COUNT  = 3'd0;
    localparam logic [2:0] KIND_SUM    = 3'd1;
    localparam logic [2:0] KIND_SQUARE = 3'd2;
    localparam logic [2:0] KIND_PCOUNT = 3'd3;
    localparam logic [2:0] KIND_PSUM   = 3'd4;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_EOE    = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [CH_W-1:0]          channel;
        logic                     hg_valid;
        logic signed [VAL_W-1:0]  hg_value;
        logic                     lg_valid;
        logic signed [VAL_W-1:0]  lg_value;
        logic                     read_gain;
        logic [2:0]               read_kind;
        logic [CH_W-1:0]          read_first;
        logic [PADDR_W-1:0]       pair_addr;
        logic                     bad;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

    typedef struct packed {
        logic [1:0] q_count;
    } front_stat_t;

    // Position of pair (a, b), a < b, in the lexicographic pair order.
    function automatic logic [SLOT_W-1:0] pair_slot(input logic [CH_W-1:0] a,
                                                    input logic [CH_W-1:0] b);
        logic [CHX_W-1:0]  rem;
        logic [PROD_W-1:0] prod;
        rem  = CHX_W'(2 * NUM_CH - 1) - {1'b0, a};
        prod = PROD_W'(a) * PROD_W'(rem);
        return SLOT_W'(prod >> 1) + SLOT_W'(b) - SLOT_W'(a) - SLOT_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ design/mcca_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mcca_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [mcca_pkg::CHX_W-1:0]    n_active,
    input  wire mcca_pkg::back_stat_t          back_stat,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_req_type,
    input  wire logic [5:0]                    s_channel,
    input  wire logic                          s_hg_valid,
    input  wire logic signed [20:0]            s_hg_value,
    input  wire logic                          s_lg_valid,
    input  wire logic signed [20:0]            s_lg_value,
    input  wire logic                          s_read_gain,
    input  wire logic [2:0]                    s_read_kind,
    input  wire logic [5:0]                    s_read_first,
    input  wire logic [5:0]                    s_read_second,
    output logic                               q_valid,
    output mcca_pkg::cmd_t                     q_head,
    input  wire logic                          q_pop,
    output mcca_pkg::front_stat_t              front_stat
);
    import mcca_pkg::*;

    cmd_t        q_mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    cmd_t        cmd_in;
    logic        in_range;
    logic        first_ok;
    logic        pair_ok;
    logic [SLOT_W-1:0] slot;
    logic        push;

    always_comb begin
        in_range = {1'b0, s_channel} < CHX_W'(NUM_CH);
        first_ok = {1'b0, s_read_first} < n_active;
        pair_ok  = (s_read_first < s_read_second) && ({1'b0, s_read_second} < n_active);
        slot     = pair_slot(s_read_first, s_read_second);

        cmd_in.op         = op_t'(s_req_type);
        cmd_in.channel    = s_channel;
        cmd_in.hg_valid   = s_hg_valid && in_range;
        cmd_in.hg_value   = s_hg_value;
        cmd_in.lg_valid   = s_lg_valid && in_range;
        cmd_in.lg_value   = s_lg_value;
        cmd_in.read_gain  = s_read_gain;
        cmd_in.read_kind  = s_read_kind;
        cmd_in.read_first = s_read_first;
        cmd_in.pair_addr  = s_read_gain ? PADDR_W'(slot) + PADDR_W'(NPAIRS)
                                        : PADDR_W'(slot);
        if (s_read_kind == KIND_COUNT || s_read_kind == KIND_SUM ||
                s_read_kind == KIND_SQUARE) begin
            cmd_in.bad = !first_ok;
        end else if (s_read_kind == KIND_PCOUNT || s_read_kind == KIND_PSUM) begin
            cmd_in.bad = !pair_ok;
        end else begin
            cmd_in.bad = 1'b1;
        end
    end

    assign s_ready  = (count_reg != 2'd2) && !back_stat.clearing;
    assign push     = s_valid && s_ready;
    assign q_valid  = count_reg != 2'd0;
    assign q_head   = q_mem_reg[rd_ptr_reg];
    assign front_stat.q_count = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

`default_nettype wire

@@ design/mcca_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mcca_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [mcca_pkg::CHX_W-1:0]    n_active,
    input  wire logic                          cov_en,
    input  wire logic                          q_valid,
    input  wire mcca_pkg::cmd_t                q_head,
    output logic                               q_pop,
    output mcca_pkg::back_stat_t               back_stat,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [63:0]                 m_read_value,
    output logic                               m_status
);
    import mcca_pkg::*;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_CH, ST_CH_MUL, ST_CH_WR,
        ST_PR, ST_PR_MUL, ST_PR_WR, ST_RD, ST_RD_OUT, ST_DONE
    } state_t;

    state_t                    state_reg;
    logic                      gain_reg;
    logic [CHX_W-1:0]          i_reg;
    logic [CHX_W-1:0]          j_reg;
    logic [SLOT_W-1:0]         base_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [PADDR_W-1:0]        clr_reg;
    logic                      clr_reply_reg;
    cmd_t                      cmd_reg;
    logic signed [VAL_W-1:0]   a_reg;
    logic signed [2*VAL_W-1:0] mul_reg;
    logic [SUM_W-1:0]          res_value_reg;
    logic                      res_status_reg;
    logic [CDEPTH-1:0]         marks_reg;
    logic                      out_valid_reg;
    logic [SUM_W-1:0]          out_value_reg;
    logic                      out_status_reg;

    logic [VAL_W-1:0]   hg_mem [NUM_CH];
    logic [VAL_W-1:0]   lg_mem [NUM_CH];
    logic [CNT_W-1:0]   cnt_mem [CDEPTH];
    logic [SUM_W-1:0]   sum_mem [CDEPTH];
    logic [SUM_W-1:0]   sq_mem [CDEPTH];
    logic [CNT_W-1:0]   pcnt_mem [PDEPTH];
    logic [SUM_W-1:0]   psum_mem [PDEPTH];

    logic [VAL_W-1:0]   hg_rd_reg, lg_rd_reg;
    logic [CNT_W-1:0]   cnt_rd_reg, pcnt_rd_reg;
    logic [SUM_W-1:0]   sum_rd_reg, sq_rd_reg, psum_rd_reg;

    logic                    hg_we, lg_we, val_rd_en;
    logic [CH_W-1:0]         val_rd_addr;
    logic                    chan_rd_en, chan_we;
    logic [CADDR_W-1:0]      chan_rd_addr, chan_wr_addr;
    logic [CNT_W-1:0]        cnt_wd;
    logic [SUM_W-1:0]        sum_wd, sq_wd;
    logic                    pair_rd_en, pair_we;
    logic [PADDR_W-1:0]      pair_rd_addr, pair_wr_addr;
    logic [CNT_W-1:0]        pcnt_wd;
    logic [SUM_W-1:0]        psum_wd;

    logic signed [VAL_W-1:0] val_rd;
    logic [CADDR_W-1:0]      cidx_i, cidx_j;
    logic [PADDR_W-1:0]      slot_addr;
    logic                    i_live, j_live, out_free;

    assign val_rd    = gain_reg ? lg_rd_reg : hg_rd_reg;
    assign cidx_i    = {gain_reg, i_reg[CH_W-1:0]};
    assign cidx_j    = {gain_reg, j_reg[CH_W-1:0]};
    assign slot_addr = gain_reg ? PADDR_W'(slot_reg) + PADDR_W'(NPAIRS)
                                : PADDR_W'(slot_reg);
    assign i_live    = i_reg < n_active;
    assign j_live    = j_reg < n_active;
    assign out_free  = !out_valid_reg || m_ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign back_stat.clearing = state_reg == ST_CLR;

    assign m_valid      = out_valid_reg;
    assign m_read_value = out_value_reg;
    assign m_status     = out_status_reg;

    always_comb begin
        hg_we        = 1'b0;
        lg_we        = 1'b0;
        val_rd_en    = 1'b0;
        val_rd_addr  = i_reg[CH_W-1:0];
        chan_rd_en   = 1'b0;
        chan_rd_addr = cidx_i;
        chan_we      = 1'b0;
        chan_wr_addr = cidx_i;
        cnt_wd       = cnt_rd_reg + CNT_W'(1);
        sum_wd       = sum_rd_reg + {{(SUM_W-VAL_W){a_reg[VAL_W-1]}}, a_reg};
        sq_wd        = sq_rd_reg + {{(SUM_W-2*VAL_W){mul_reg[2*VAL_W-1]}}, mul_reg};
        pair_rd_en   = 1'b0;
        pair_rd_addr = slot_addr;
        pair_we      = 1'b0;
        pair_wr_addr = slot_addr;
        pcnt_wd      = pcnt_rd_reg + CNT_W'(1);
        psum_wd      = psum_rd_reg + {{(SUM_W-2*VAL_W){mul_reg[2*VAL_W-1]}}, mul_reg};
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_head.op == OP_SAMPLE) begin
                    hg_we = q_head.hg_valid;
                    lg_we = q_head.lg_valid;
                end
            end
            ST_CH: begin
                if (i_live && marks_reg[cidx_i]) begin
                    val_rd_en  = 1'b1;
                    chan_rd_en = 1'b1;
                end
            end
            ST_CH_WR: begin
                chan_we = 1'b1;
            end
            ST_PR: begin
                val_rd_addr = j_reg[CH_W-1:0];
                if (j_live && marks_reg[cidx_j]) begin
                    val_rd_en  = 1'b1;
                    pair_rd_en = 1'b1;
                end
            end
            ST_PR_WR: begin
                pair_we = 1'b1;
            end
            ST_RD: begin
                chan_rd_en   = 1'b1;
                chan_rd_addr = {cmd_reg.read_gain, cmd_reg.read_first};
                pair_rd_en   = 1'b1;
                pair_rd_addr = cmd_reg.pair_addr;
            end
            ST_CLR: begin
                pair_we      = 1'b1;
                pair_wr_addr = clr_reg;
                pcnt_wd      = '0;
                psum_wd      = '0;
                chan_we      = clr_reg < PADDR_W'(CDEPTH);
                chan_wr_addr = CADDR_W'(clr_reg);
                cnt_wd       = '0;
                sum_wd       = '0;
                sq_wd        = '0;
            end
            default: begin
            end
        endcase
    end

    // Event value stores, one per gain.
    always_ff @(posedge aclk) begin
        if (hg_we) begin
            hg_mem[q_head.channel] <= q_head.hg_value;
        end
        if (lg_we) begin
            lg_mem[q_head.channel] <= q_head.lg_value;
        end
        if (val_rd_en) begin
            hg_rd_reg <= hg_mem[val_rd_addr];
            lg_rd_reg <= lg_mem[val_rd_addr];
        end
    end

    // Per-channel accumulators.
    always_ff @(posedge aclk) begin
        if (chan_we) begin
            cnt_mem[chan_wr_addr] <= cnt_wd;
            sum_mem[chan_wr_addr] <= sum_wd;
            sq_mem[chan_wr_addr]  <= sq_wd;
        end
        if (chan_rd_en) begin
            cnt_rd_reg <= cnt_mem[chan_rd_addr];
            sum_rd_reg <= sum_mem[chan_rd_addr];
            sq_rd_reg  <= sq_mem[chan_rd_addr];
        end
    end

    // Pair accumulators.
    always_ff @(posedge aclk) begin
        if (pair_we) begin
            pcnt_mem[pair_wr_addr] <= pcnt_wd;
            psum_mem[pair_wr_addr] <= psum_wd;
        end
        if (pair_rd_en) begin
            pcnt_rd_reg <= pcnt_mem[pair_rd_addr];
            psum_rd_reg <= psum_mem[pair_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLR;
            clr_reg        <= '0;
            clr_reply_reg  <= 1'b0;
            marks_reg      <= '0;
            out_valid_reg  <= 1'b0;
            gain_reg       <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            base_reg       <= '0;
            slot_reg       <= '0;
        end else begin
            // A word leaving the output register frees it, unless a new one
            // is loaded in the same cycle.
            if (out_valid_reg && m_ready && state_reg != ST_DONE) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLR: begin
                    if (clr_reg == PADDR_W'(PDEPTH - 1)) begin
                        clr_reg   <= '0;
                        state_reg <= clr_reply_reg ? ST_DONE : ST_IDLE;
                    end else begin
                        clr_reg <= clr_reg + PADDR_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        cmd_reg        <= q_head;
                        res_value_reg  <= '0;
                        res_status_reg <= 1'b0;
                        unique case (q_head.op)
                            OP_SAMPLE: begin
                                marks_reg <= marks_reg
                                    | (CDEPTH'(q_head.hg_valid) << {1'b0, q_head.channel})
                                    | (CDEPTH'(q_head.lg_valid) << {1'b1, q_head.channel});
                                state_reg <= ST_DONE;
                            end
                            OP_EOE: begin
                                gain_reg  <= 1'b0;
                                i_reg     <= '0;
                                base_reg  <= '0;
                                state_reg <= ST_CH;
                            end
                            OP_READ: begin
                                state_reg <= ST_RD;
                            end
                            OP_CLEAR: begin
                                marks_reg     <= '0;
                                clr_reply_reg <= 1'b1;
                                state_reg     <= ST_CLR;
                            end
                        endcase
                    end
                end
                ST_CH: begin
                    if (!i_live) begin
                        // This gain is done: its marks are spent.
                        if (gain_reg) begin
                            marks_reg[NUM_CH +: NUM_CH] <= '0;
                            state_reg <= ST_DONE;
                        end else begin
                            marks_reg[0 +: NUM_CH] <= '0;
                            gain_reg <= 1'b1;
                            i_reg    <= '0;
                            base_reg <= '0;
                        end
                    end else if (!marks_reg[cidx_i]) begin
                        i_reg    <= i_reg + CHX_W'(1);
                        base_reg <= base_reg + SLOT_W'(NUM_CH - 1) - SLOT_W'(i_reg);
                    end else begin
                        state_reg <= ST_CH_MUL;
                    end
                end
                ST_CH_MUL: begin
                    a_reg     <= val_rd;
                    mul_reg   <= val_rd * val_rd;
                    state_reg <= ST_CH_WR;
                end
                ST_CH_WR: begin
                    if (cov_en) begin
                        j_reg     <= i_reg + CHX_W'(1);
                        slot_reg  <= base_reg;
                        state_reg <= ST_PR;
                    end else begin
                        i_reg     <= i_reg + CHX_W'(1);
                        base_reg  <= base_reg + SLOT_W'(NUM_CH - 1) - SLOT_W'(i_reg);
                        state_reg <= ST_CH;
                    end
                end
                ST_PR: begin
                    if (!j_live) begin
                        i_reg     <= i_reg + CHX_W'(1);
                        base_reg  <= base_reg + SLOT_W'(NUM_CH - 1) - SLOT_W'(i_reg);
                        state_reg <= ST_CH;
                    end else if (!marks_reg[cidx_j]) begin
                        j_reg    <= j_reg + CHX_W'(1);
                        slot_reg <= slot_reg + SLOT_W'(1);
                    end else begin
                        state_reg <= ST_PR_MUL;
                    end
                end
                ST_PR_MUL: begin
                    mul_reg   <= a_reg * val_rd;
                    state_reg <= ST_PR_WR;
                end
                ST_PR_WR: begin
                    j_reg     <= j_reg + CHX_W'(1);
                    slot_reg  <= slot_reg + SLOT_W'(1);
                    state_reg <= ST_PR;
                end
                ST_RD: begin
                    state_reg <= ST_RD_OUT;
                end
                ST_RD_OUT: begin
                    res_status_reg <= cmd_reg.bad;
                    if (cmd_reg.bad) begin
                        res_value_reg <= '0;
                    end else if (cmd_reg.read_kind == KIND_COUNT) begin
                        res_value_reg <= SUM_W'(cnt_rd_reg);
                    end else if (cmd_reg.read_kind == KIND_SUM) begin
                        res_value_reg <= sum_rd_reg;
                    end else if (cmd_reg.read_kind == KIND_SQUARE) begin
                        res_value_reg <= sq_rd_reg;
                    end else if (cmd_reg.read_kind == KIND_PCOUNT) begin
                        res_value_reg <= SUM_W'(pcnt_rd_reg);
                    end else begin
                        res_value_reg <= psum_rd_reg;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= res_value_reg;
                        out_status_reg <= res_status_reg;
                        clr_reply_reg  <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/masked_channel_covariance_accumulator.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Masked channel covariance accumulator. Every input word yields exactly one
// result word. A read word reads the accumulators and then selects the
// result. An end of event word walks both gains channel by channel; an absent
// channel is skipped, and a present one is read, squared and written back.
// With covariance enabled every present channel also walks the channels
// above it, skipping absent partners and reading, multiplying and writing
// back present ones. The walk is sequential because of the single read and
// write port of the accumulator memories, which one sequencer walks through.
// After reset and after every clear word the pair memories are swept one
// entry per cycle over 4032 entries, clearing the channel memories as well,
// during which no input word is taken; configuration writes are taken at any
// time. A front queue of two words and an output register let either side
// stall without holding the other.
module masked_channel_covariance_accumulator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_index,
    input  wire logic [mcca_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_req_type,
    input  wire logic [5:0]                    s_channel,
    input  wire logic                          s_hg_valid,
    input  wire logic signed [20:0]            s_hg_value,
    input  wire logic                          s_lg_valid,
    input  wire logic signed [20:0]            s_lg_value,
    input  wire logic                          s_read_gain,
    input  wire logic [2:0]                    s_read_kind,
    input  wire logic [5:0]                    s_read_first,
    input  wire logic [5:0]                    s_read_second,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [63:0]                 m_read_value,
    output logic                               m_status
);
    import mcca_pkg::*;

    logic              cov_en_reg;
    logic [CFG_W-1:0]  ch_in_use_reg;
    logic [CHX_W-1:0]  n_active;
    logic              q_valid;
    logic              q_pop;
    cmd_t              q_head;
    back_stat_t        back_stat;
    front_stat_t       front_stat;

    // Configuration registers; the effective channel count is capped at the
    // number of channels the block is built for.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cov_en_reg    <= 1'b0;
            ch_in_use_reg <= CFG_W'(64);
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_COV_EN) begin
                cov_en_reg <= cfg_data[0];
            end else if (cfg_index == REG_CH_IN_USE) begin
                ch_in_use_reg <= cfg_data;
            end
        end
    end

    assign n_active = (ch_in_use_reg < CFG_W'(NUM_CH)) ? CHX_W'(ch_in_use_reg)
                                                      : CHX_W'(NUM_CH);

    // The front accepts and classifies words, checks read indexes and works
    // out pair addresses, then queues them for the back.
    mcca_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .n_active      (n_active),
        .back_stat     (back_stat),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_channel     (s_channel),
        .s_hg_valid    (s_hg_valid),
        .s_hg_value    (s_hg_value),
        .s_lg_valid    (s_lg_valid),
        .s_lg_value    (s_lg_value),
        .s_read_gain   (s_read_gain),
        .s_read_kind   (s_read_kind),
        .s_read_first  (s_read_first),
        .s_read_second (s_read_second),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .front_stat    (front_stat)
    );

    // The back owns the memories and the sequencer that walks them.
    mcca_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .n_active     (n_active),
        .cov_en       (cov_en_reg),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .back_stat    (back_stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status)
    );

    // No word may enter while the memories are being swept.
    `MCCA_ASSERT_IMPLY(a_sweep_blocks_input, aclk, aresetn, back_stat.clearing, !s_ready)
    // A bad read always reports a zero value.
    `MCCA_ASSERT_IMPLY(a_bad_read_zero, aclk, aresetn, m_valid && m_status, m_read_value == '0)
    // The queue never takes a word when it is full.
    `MCCA_ASSERT_IMPLY(a_queue_no_overflow, aclk, aresetn, s_valid && s_ready, front_stat.q_count != 2'd2)
    // A word taken into an empty queue is visible to the back next cycle.
    `MCCA_ASSERT_NEXT(a_queue_fills, aclk, aresetn, s_valid && s_ready && front_stat.q_count == 2'd0, q_valid)

endmodule

`default_nettype wire
